// ===== hw/rtl/sddcwd_pkg.sv =====
// ----------------------------------------------------------------------------
// sddcwd_pkg
// Shared types and constants of the compressed drift detector word decoder.
// ----------------------------------------------------------------------------
package sddcwd_pkg;

   localparam int RAW_W     = 32;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 64;
   localparam int THR_N     = 24;   // board*2+side for boards 0..11
   localparam int THR_IDX_W = $clog2(THR_N);

   localparam logic [3:0] BOARD_NO_THR = 4'd12;   // boards from here on use zero

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ADC_ENCODED  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLDS_A = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLDS_B = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLDS_C = 8'd3;

   // control nibbles
   localparam logic [3:0] NIB_JITTER = 4'h8;
   localparam logic [3:0] NIB_EOM    = 4'hF;

   // result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_EOM  = 2'd1;
   localparam logic [1:0] KIND_LINK = 2'd2;

   typedef struct packed {
      logic                  adc_encoded;
      logic [THR_N-1:0][7:0] thr;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] board_id;
      logic       side;
      logic [7:0] anode;
      logic [7:0] time_bin;
      logic [7:0] adc;      // low 8 bits of ADC, later ADC plus threshold
      logic [7:0] jitter;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] board_id;
      logic       side;
      logic [7:0] anode;
      logic [7:0] time_bin;
      logic [9:0] signal;
      logic [7:0] jitter;
   } result_type;

endpackage

// ===== hw/rtl/sddcwd_csr.sv =====
// ----------------------------------------------------------------------------
// sddcwd_csr
// Configuration registers: ADC mode and the packed per board/side thresholds.
// ----------------------------------------------------------------------------
module sddcwd_csr
   import sddcwd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output cfg_type              cfg
);

   logic                 adc_encoded_ff;
   logic [CSR_DAT_W-1:0] thr_a_ff;
   logic [CSR_DAT_W-1:0] thr_b_ff;
   logic [CSR_DAT_W-1:0] thr_c_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_encoded_ff <= 1'b0;
         thr_a_ff       <= '0;
         thr_b_ff       <= '0;
         thr_c_ff       <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ADC_ENCODED:  adc_encoded_ff <= csr_wdata[0];
            REG_THRESHOLDS_A: thr_a_ff       <= csr_wdata;
            REG_THRESHOLDS_B: thr_b_ff       <= csr_wdata;
            REG_THRESHOLDS_C: thr_c_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // byte k of the concatenation is threshold index k
   assign cfg.adc_encoded = adc_encoded_ff;
   assign cfg.thr         = {thr_c_ff, thr_b_ff, thr_a_ff};

endmodule

// ===== hw/rtl/sddcwd_unpack.sv =====
// ----------------------------------------------------------------------------
// sddcwd_unpack
// Stage 1: classifies the raw word, unpacks data fields and the ADC value.
// Words that give no result are dropped here.
// ----------------------------------------------------------------------------
module sddcwd_unpack
   import sddcwd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adc_encoded,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [RAW_W-1:0] raw_word,
   output logic             out_valid,
   input  logic             out_ready,
   output item_type         out_item
);

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     keep;
   logic [2:0] code;
   logic [7:0] mant;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      code    = raw_word[2:0];
      mant    = {1'b0, raw_word[9:3]} & ((8'd1 << code) - 8'd1);
      item_in = '0;
      keep    = 1'b0;
      if (raw_word == '1) begin
         keep = 1'b0;   // header word
      end else if (raw_word[31:28] == NIB_EOM) begin
         keep             = 1'b1;
         item_in.kind     = KIND_EOM;
         item_in.board_id = raw_word[3:0];
      end else if (raw_word[31:28] == NIB_JITTER) begin
         keep           = 1'b1;
         item_in.kind   = KIND_LINK;
         item_in.jitter = raw_word[7:0];
      end else if (!raw_word[31]) begin
         item_in.kind     = KIND_DATA;
         item_in.board_id = raw_word[30:27];
         item_in.side     = raw_word[26];
         item_in.anode    = raw_word[25:18];
         item_in.time_bin = raw_word[17:10];
         if (adc_encoded) begin
            keep        = (code >= 3'd2);
            item_in.adc = mant + (8'd1 << code);
         end else begin
            keep        = 1'b1;
            item_in.adc = raw_word[7:0];   // only the low byte survives the sum
         end
      end
   end

   always_comb begin
      vld_in = vld_ff && !out_ready;
      if (in_valid && in_ready) vld_in = keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) item_ff <= item_in;
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/sddcwd_thr_add.sv =====
// ----------------------------------------------------------------------------
// sddcwd_thr_add
// Stage 2: looks up the board/side threshold and adds it to the ADC byte.
// ----------------------------------------------------------------------------
module sddcwd_thr_add
   import sddcwd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   logic     vld_ff;
   item_type item_ff, item_in;
   logic [THR_IDX_W-1:0] thr_idx;
   logic [7:0]           thr;

   assign in_ready = !vld_ff || out_ready;
   assign thr_idx  = {in_item.board_id, in_item.side};

   always_comb begin
      thr = 8'd0;
      if (in_item.board_id < BOARD_NO_THR) thr = cfg.thr[thr_idx];
      item_in     = in_item;
      item_in.adc = in_item.adc + thr;   // wraps mod 256
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) item_ff <= item_in;
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/sddcwd_expand.sv =====
// ----------------------------------------------------------------------------
// sddcwd_expand
// Stage 3: piecewise 8-to-10-bit decompression into the output register.
// ----------------------------------------------------------------------------
module sddcwd_expand
   import sddcwd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   localparam logic [9:0] SEG1_ODD  = 10'h080;
   localparam logic [9:0] SEG1_EVEN = 10'h081;
   localparam logic [9:0] SEG2_ODD  = 10'h103;
   localparam logic [9:0] SEG2_EVEN = 10'h104;
   localparam logic [9:0] SEG3_ODD  = 10'h207;
   localparam logic [9:0] SEG3_EVEN = 10'h208;

   function automatic logic [9:0] expand8to10(input logic [7:0] v);
      logic [9:0] r;
      if (!v[7]) begin
         r = {3'b0, v[6:0]};
      end else if (!v[6]) begin
         r = (v[0] ? SEG1_ODD : SEG1_EVEN) + {3'b0, v[5:0], 1'b0};
      end else if (!v[5]) begin
         r = (v[0] ? SEG2_ODD : SEG2_EVEN) + {2'b0, v[4:0], 3'b0};
      end else begin
         r = (v[0] ? SEG3_ODD : SEG3_EVEN) + {1'b0, v[4:0], 4'b0};
      end
      return r;
   endfunction

   logic       vld_ff;
   result_type res_ff, res_in;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      res_in.kind     = in_item.kind;
      res_in.board_id = in_item.board_id;
      res_in.side     = in_item.side;
      res_in.anode    = in_item.anode;
      res_in.time_bin = in_item.time_bin;
      res_in.jitter   = in_item.jitter;
      res_in.signal   = (in_item.kind == KIND_DATA) ? expand8to10(in_item.adc) : 10'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) res_ff <= res_in;
   end

   assign out_valid  = vld_ff;
   assign out_result = res_ff;

endmodule

// ===== hw/rtl/sdd_compressed_word_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// sdd_compressed_word_decoder_unit
// Decoder for the compressed drift detector raw word stream.
// ----------------------------------------------------------------------------
// Takes up to one 32-bit raw word per cycle and returns at most one decoded word:
// a data digit, an end of module marker or an end of link jitter word. The
// path is three register stages (unpack, threshold add, decompression and
// output register), and a new word is accepted every cycle while the output
// side keeps up. Each stage has its own valid bit and holds its data on a
// stall; headers, JTAG and unknown control words and words with a bad range
// code are dropped in the first stage. Configuration is written through the
// csr port, which is always ready.
module sdd_compressed_word_decoder_unit
   import sddcwd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RAW_W-1:0]     req_raw_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_word_kind,
   output logic [3:0]           rsp_board_id,
   output logic                 rsp_side,
   output logic [7:0]           rsp_anode,
   output logic [7:0]           rsp_time_bin,
   output logic [9:0]           rsp_signal,
   output logic [7:0]           rsp_jitter,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type    cfg;
   logic       s1_valid, s1_ready;
   item_type   s1_item;
   logic       s2_valid, s2_ready;
   item_type   s2_item;
   result_type result;

   sddcwd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sddcwd_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .adc_encoded (cfg.adc_encoded),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .raw_word    (req_raw_word),
      .out_valid   (s1_valid),
      .out_ready   (s1_ready),
      .out_item    (s1_item)
   );

   sddcwd_thr_add u_thr_add (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_item   (s1_item),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_item  (s2_item)
   );

   sddcwd_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_ready   (s2_ready),
      .in_item    (s2_item),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_word_kind = result.kind;
   assign rsp_board_id  = result.board_id;
   assign rsp_side      = result.side;
   assign rsp_anode     = result.anode;
   assign rsp_time_bin  = result.time_bin;
   assign rsp_signal    = result.signal;
   assign rsp_jitter    = result.jitter;

endmodule
